// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define NMS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds.
`define NMS_NEVER(label, cond, msg) \
	`NMS_ASSERT(label, !(cond), msg)

`endif

// ===== src/nms_pkg.sv =====
package nms_pkg;

	localparam int MAX_BOXES_DEF      = 64;
	localparam int EXP_TABLE_SIZE_DEF = 256;
	localparam int ONE_PIXEL          = 16;
	localparam int WT_W               = 18;
	localparam int TW_W               = 24;
	localparam int SUM_W              = 40;
	localparam int NFLD               = 5;
	localparam int REG_IDX_W          = 2;

	localparam logic [REG_IDX_W-1:0] REG_IOU_THRESHOLD = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BLEND_MODE    = 2'd1;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic issue;
		logic absorb;
		logic lead_rd;
		logic lead_set;
		logic div_start;
		logic div_step;
		logic set_clr;
	} cmd_t;

	typedef struct packed {
		logic last_idx;
		logic pipe_busy;
		logic div_last;
		logic set_done;
		logic blend;
	} sts_t;

endpackage

// ===== src/nms_ctrl.sv =====
module nms_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output nms_pkg::cmd_t cmd,
	input  nms_pkg::sts_t sts
);

	typedef enum logic [8:0] {
		ST_LOAD  = 9'b000000001,
		ST_LSCAN = 9'b000000010,
		ST_LWAIT = 9'b000000100,
		ST_LBOX  = 9'b000001000,
		ST_LSET  = 9'b000010000,
		ST_ASCAN = 9'b000100000,
		ST_AWAIT = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall  = (state_q != ST_LOAD);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.scan_clr = 1'b1;
						state_d      = ST_LSCAN;
					end
				end
			end
			ST_LSCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_idx) begin
					state_d = ST_LWAIT;
				end
			end
			ST_LWAIT: begin
				state_d = ST_LBOX;
			end
			ST_LBOX: begin
				cmd.lead_rd = 1'b1;
				state_d     = ST_LSET;
			end
			ST_LSET: begin
				cmd.lead_set = 1'b1;
				state_d      = ST_ASCAN;
			end
			ST_ASCAN: begin
				cmd.issue  = 1'b1;
				cmd.absorb = 1'b1;
				if (sts.last_idx) begin
					state_d = ST_AWAIT;
				end
			end
			ST_AWAIT: begin
				if (!sts.pipe_busy) begin
					if (sts.blend) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					if (sts.set_done) begin
						cmd.set_clr = 1'b1;
						state_d     = ST_LOAD;
					end else begin
						cmd.scan_clr = 1'b1;
						state_d      = ST_LSCAN;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/nms_dp.sv =====
`include "assert_macros.svh"

module nms_dp #(
	parameter int MAX_BOXES      = nms_pkg::MAX_BOXES_DEF,
	parameter int EXP_TABLE_SIZE = nms_pkg::EXP_TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nms_pkg::cmd_t                 cmd,
	output nms_pkg::sts_t                 sts,
	input  logic                          cfg_write,
	input  logic [nms_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic [15:0]                   in_x1,
	input  logic [15:0]                   in_y1,
	input  logic [15:0]                   in_x2,
	input  logic [15:0]                   in_y2,
	input  logic [15:0]                   in_score,
	input  logic [7:0]                    in_class,
	output logic [15:0]                   out_x1,
	output logic [15:0]                   out_y1,
	output logic [15:0]                   out_x2,
	output logic [15:0]                   out_y2,
	output logic [15:0]                   out_score,
	output logic [7:0]                    out_class,
	output logic                          out_last
);

	localparam int IW    = $clog2(MAX_BOXES);
	localparam int CW    = $clog2(MAX_BOXES + 1);
	localparam int KW    = $clog2(EXP_TABLE_SIZE);
	localparam int WT_W  = nms_pkg::WT_W;
	localparam int TW_W  = nms_pkg::TW_W;
	localparam int SUM_W = nms_pkg::SUM_W;
	localparam int NFLD  = nms_pkg::NFLD;

	// Weight table: e^(k/size) in Q2.16 from a truncated Taylor series.
	logic [WT_W-1:0] exp_rom [EXP_TABLE_SIZE];

	for (genvar g = 0; g < EXP_TABLE_SIZE; g++) begin : g_rom
		localparam longint unsigned K   = 64'(g);
		localparam longint unsigned T0  = 64'd1 << 30;
		localparam longint unsigned T1  = (T0 * K) / (1 * EXP_TABLE_SIZE);
		localparam longint unsigned T2  = (T1 * K) / (2 * EXP_TABLE_SIZE);
		localparam longint unsigned T3  = (T2 * K) / (3 * EXP_TABLE_SIZE);
		localparam longint unsigned T4  = (T3 * K) / (4 * EXP_TABLE_SIZE);
		localparam longint unsigned T5  = (T4 * K) / (5 * EXP_TABLE_SIZE);
		localparam longint unsigned T6  = (T5 * K) / (6 * EXP_TABLE_SIZE);
		localparam longint unsigned T7  = (T6 * K) / (7 * EXP_TABLE_SIZE);
		localparam longint unsigned T8  = (T7 * K) / (8 * EXP_TABLE_SIZE);
		localparam longint unsigned T9  = (T8 * K) / (9 * EXP_TABLE_SIZE);
		localparam longint unsigned T10 = (T9 * K) / (10 * EXP_TABLE_SIZE);
		localparam longint unsigned T11 = (T10 * K) / (11 * EXP_TABLE_SIZE);
		localparam longint unsigned T12 = (T11 * K) / (12 * EXP_TABLE_SIZE);
		localparam longint unsigned S   = T0 + T1 + T2 + T3 + T4 + T5 + T6
			+ T7 + T8 + T9 + T10 + T11 + T12;
		assign exp_rom[g] = WT_W'(S >> 14);
	end

	// Configuration
	logic [15:0] thr_q;
	logic        blend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= 16'd32768;
			blend_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				nms_pkg::REG_IOU_THRESHOLD: thr_q   <= cfg_data;
				nms_pkg::REG_BLEND_MODE:    blend_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Leader search and stage-1 control
	logic [63:0]   box_s1;
	logic [23:0]   sc_s1;
	logic          v_s1, a_s1, self_s1;
	logic [IW-1:0] idx_s1;
	logic          found_q;
	logic [IW-1:0] best_idx_q;
	logic [15:0]   best_score_q;
	logic [7:0]    best_class_q;
	logic [63:0]   lead_q;
	logic [16:0]   lead_w_q, lead_h_q;
	logic          hit;

	logic                  v_s2, v_s3, v_s4, v_s5;
	logic                  self_s2, self_s3, self_s4, self_s5;
	logic                  pos_s2, pos_s3, pos_s4, pos_s5;
	logic [IW-1:0]         idx_s2, idx_s3, idx_s4, idx_s5;
	logic [WT_W-1:0]       wt_s2, wt_s3, wt_s4, wt_s5;
	logic [16:0]           iw_s2, ih_s2, w1_s2, h1_s2;
	logic [NFLD-1:0][15:0] fld_s2;
	logic [33:0]           inner_s3, a1_s3, a0_s3, inner_s4, inner_s5;
	logic [NFLD-1:0][33:0] pw_s3, pw_s4, pw_s5;
	logic [34:0]           uni_s4;
	logic [33:0]           tlo_s5;
	logic [32:0]           thi_s5;

	// Storage
	logic [63:0] box_mem [MAX_BOXES];
	logic [23:0] sc_mem  [MAX_BOXES];
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;
	logic [MAX_BOXES-1:0] merged_q;
	logic [CW-1:0] mcnt_q;
	logic [IW-1:0] rd_addr;

	assign rd_addr = cmd.lead_rd ? best_idx_q : idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load && (count_q < CW'(MAX_BOXES))) begin
			box_mem[count_q[IW-1:0]] <= {in_x1, in_y1, in_x2, in_y2};
			sc_mem[count_q[IW-1:0]]  <= {in_score, in_class};
		end
		box_s1 <= box_mem[rd_addr];
		sc_s1  <= sc_mem[rd_addr];
	end

	function automatic logic [17:0] side(input logic [15:0] lo, input logic [15:0] hi);
		side = 18'(hi) - 18'(lo) + 18'(nms_pkg::ONE_PIXEL);
	endfunction

	logic [17:0] lw_c, lh_c;
	assign lw_c = side(box_s1[63:48], box_s1[31:16]);
	assign lh_c = side(box_s1[47:32], box_s1[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			idx_q    <= '0;
			merged_q <= '0;
			mcnt_q   <= '0;
			v_s1     <= 1'b0;
			a_s1     <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (cmd.load && (count_q < CW'(MAX_BOXES))) begin
				count_q <= count_q + CW'(1);
			end
			v_s1 <= cmd.issue && !merged_q[idx_q];
			a_s1 <= cmd.absorb;
			if (cmd.scan_clr || cmd.lead_set) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.scan_clr) begin
				found_q <= 1'b0;
			end else if (v_s1 && !a_s1 && (!found_q || sc_s1[23:8] > best_score_q)) begin
				found_q <= 1'b1;
			end
			if (hit) begin
				merged_q[idx_s5] <= 1'b1;
				mcnt_q           <= mcnt_q + CW'(1);
			end
			if (cmd.set_clr) begin
				count_q  <= '0;
				merged_q <= '0;
				mcnt_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		self_s1 <= (idx_q == best_idx_q);
		if (v_s1 && !a_s1 && (!found_q || sc_s1[23:8] > best_score_q)) begin
			best_idx_q   <= idx_s1;
			best_score_q <= sc_s1[23:8];
			best_class_q <= sc_s1[7:0];
		end
		if (cmd.lead_set) begin
			lead_q   <= box_s1;
			lead_w_q <= lw_c[16:0];
			lead_h_q <= lh_c[16:0];
		end
	end

	// Overlap and weighting pipeline
	logic [31:0]   kprod;
	logic [KW-1:0] kidx;
	logic [15:0]   ix1, iy1, ix2, iy2;
	logic [17:0]   iw_c, ih_c;

	assign kprod = 32'(sc_s1[23:8]) * 32'(EXP_TABLE_SIZE);
	assign kidx  = kprod[16 +: KW];
	assign ix1 = (lead_q[63:48] > box_s1[63:48]) ? lead_q[63:48] : box_s1[63:48];
	assign iy1 = (lead_q[47:32] > box_s1[47:32]) ? lead_q[47:32] : box_s1[47:32];
	assign ix2 = (lead_q[31:16] < box_s1[31:16]) ? lead_q[31:16] : box_s1[31:16];
	assign iy2 = (lead_q[15:0]  < box_s1[15:0])  ? lead_q[15:0]  : box_s1[15:0];
	assign iw_c = side(ix1, ix2);
	assign ih_c = side(iy1, iy2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && a_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		self_s2 <= self_s1;
		idx_s2  <= idx_s1;
		pos_s2  <= !iw_c[17] && (iw_c != '0) && !ih_c[17] && (ih_c != '0);
		iw_s2   <= iw_c[16:0];
		ih_s2   <= ih_c[16:0];
		w1_s2   <= lw_c[16:0];
		h1_s2   <= lh_c[16:0];
		wt_s2   <= exp_rom[kidx];
		fld_s2  <= {box_s1, sc_s1[23:8]};

		self_s3  <= self_s2;
		idx_s3   <= idx_s2;
		pos_s3   <= pos_s2;
		wt_s3    <= wt_s2;
		inner_s3 <= 34'(iw_s2) * 34'(ih_s2);
		a1_s3    <= 34'(w1_s2) * 34'(h1_s2);
		a0_s3    <= 34'(lead_w_q) * 34'(lead_h_q);
		for (int f = 0; f < NFLD; f++) begin
			pw_s3[f] <= 34'(wt_s2) * 34'(fld_s2[f]);
		end

		self_s4  <= self_s3;
		idx_s4   <= idx_s3;
		pos_s4   <= pos_s3;
		wt_s4    <= wt_s3;
		pw_s4    <= pw_s3;
		inner_s4 <= inner_s3;
		uni_s4   <= 35'(a0_s3) + 35'(a1_s3) - 35'(inner_s3);

		self_s5  <= self_s4;
		idx_s5   <= idx_s4;
		pos_s5   <= pos_s4;
		wt_s5    <= wt_s4;
		pw_s5    <= pw_s4;
		inner_s5 <= inner_s4;
		tlo_s5   <= 34'(thr_q) * 34'(uni_s4[17:0]);
		thi_s5   <= 33'(thr_q) * 33'(uni_s4[34:18]);
	end

	logic [50:0] rhs, lhs;
	assign rhs = {thi_s5, 18'd0} + 51'(tlo_s5);
	assign lhs = 51'({inner_s5, 16'd0});
	assign hit = v_s5 && (self_s5 || (pos_s5 && (lhs > rhs)));

	// Group sums
	logic [NFLD-1:0][SUM_W-1:0] sum_q;
	logic [TW_W-1:0]            tw_q;

	always_ff @(posedge clk) begin
		if (cmd.lead_set) begin
			sum_q <= '0;
			tw_q  <= '0;
		end else if (hit) begin
			for (int f = 0; f < NFLD; f++) begin
				sum_q[f] <= sum_q[f] + SUM_W'(pw_s5[f]);
			end
			tw_q <= tw_q + TW_W'(wt_s5);
		end
	end

	// Restoring divider, one quotient bit per cycle, fields in turn
	logic [SUM_W-1:0]      rem_q;
	logic [3:0]            bit_q;
	logic [2:0]            fld_q;
	logic [NFLD-1:0][15:0] quo_q;
	logic [SUM_W-1:0]      tw_sh;
	logic                  ge;

	assign tw_sh = SUM_W'(tw_q) << bit_q;
	assign ge    = (rem_q >= tw_sh);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= sum_q[NFLD-1];
			bit_q <= 4'd15;
			fld_q <= 3'(NFLD - 1);
		end else if (cmd.div_step) begin
			quo_q[fld_q][bit_q] <= ge;
			if (bit_q == 4'd0) begin
				bit_q <= 4'd15;
				if (fld_q != 3'd0) begin
					fld_q <= fld_q - 3'd1;
					rem_q <= sum_q[fld_q - 3'd1];
				end
			end else begin
				bit_q <= bit_q - 4'd1;
				if (ge) begin
					rem_q <= rem_q - tw_sh;
				end
			end
		end
	end

	assign sts.last_idx  = ((CW'(idx_q) + CW'(1)) == count_q);
	assign sts.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign sts.div_last  = (bit_q == 4'd0) && (fld_q == 3'd0);
	assign sts.set_done  = (mcnt_q == count_q);
	assign sts.blend     = blend_q;

	// fld order: x1, y1, x2, y2, score from high index down
	assign out_x1    = blend_q ? quo_q[4] : lead_q[63:48];
	assign out_y1    = blend_q ? quo_q[3] : lead_q[47:32];
	assign out_x2    = blend_q ? quo_q[2] : lead_q[31:16];
	assign out_y2    = blend_q ? quo_q[1] : lead_q[15:0];
	assign out_score = blend_q ? quo_q[0] : best_score_q;
	assign out_class = best_class_q;
	assign out_last  = (mcnt_q == count_q);

	`NMS_ASSERT(a_issue_range, cmd.issue |-> (CW'(idx_q) < count_q), "scan past stored count")
	`NMS_NEVER(a_double_merge, hit && merged_q[idx_s5], "box merged twice")
	`NMS_NEVER(a_div_early, cmd.div_start && sts.pipe_busy, "divide before sums settle")

endmodule

// ===== src/box_non_max_suppression_top.sv =====
// Non-maximum suppression over up to MAX_BOXES detections. Detections are
// taken one item per cycle; the item with in_last starts processing, during
// which in_stall stays high. Each result group takes a leader search, an
// overlap pass over the N stored boxes through the pipelined IoU unit and
// an output step; in blending mode a shared restoring divider then works
// out five fields of sixteen bits each before the output step.
module box_non_max_suppression_top #(
	parameter int MAX_BOXES      = nms_pkg::MAX_BOXES_DEF,
	parameter int EXP_TABLE_SIZE = nms_pkg::EXP_TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [nms_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [15:0]                   in_x1,
	input  logic [15:0]                   in_y1,
	input  logic [15:0]                   in_x2,
	input  logic [15:0]                   in_y2,
	input  logic [15:0]                   in_score,
	input  logic [7:0]                    in_class,
	input  logic                          in_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [15:0]                   out_x1,
	output logic [15:0]                   out_y1,
	output logic [15:0]                   out_x2,
	output logic [15:0]                   out_y2,
	output logic [15:0]                   out_score,
	output logic [7:0]                    out_class,
	output logic                          out_last
);

	nms_pkg::cmd_t cmd;
	nms_pkg::sts_t sts;

	nms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_last),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	nms_dp #(
		.MAX_BOXES      (MAX_BOXES),
		.EXP_TABLE_SIZE (EXP_TABLE_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_x1     (in_x1),
		.in_y1     (in_y1),
		.in_x2     (in_x2),
		.in_y2     (in_y2),
		.in_score  (in_score),
		.in_class  (in_class),
		.out_x1    (out_x1),
		.out_y1    (out_y1),
		.out_x2    (out_x2),
		.out_y2    (out_y2),
		.out_score (out_score),
		.out_class (out_class),
		.out_last  (out_last)
	);

endmodule
